// ===== sv/rule_id_extractor_assert.svh =====
// ----------------------------------------------------------------------------
// rule id extractor assertion macros
// concurrent assertion wrappers used by rie_emit
// ----------------------------------------------------------------------------
`ifndef RULE_ID_EXTRACTOR_ASSERT_SVH
`define RULE_ID_EXTRACTOR_ASSERT_SVH

// same-cycle implication
`define RIE_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define RIE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/rie_pkg.sv =====
// ----------------------------------------------------------------------------
// rie_pkg
// shared types, marker tables and character classes of the rule id extractor
// ----------------------------------------------------------------------------
package rie_pkg;

   localparam int MAX_ID_LEN_DEF = 63;
   localparam int MARKER_CNT     = 5;
   localparam int MARKER_W       = 3;
   localparam int PROG_W         = 3;
   localparam int MARKER_MAXLEN  = 5;
   localparam int COLON_IDX      = 4;
   localparam int CAP_W          = 7;

   localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

   typedef enum logic [1:0] {
      STATUS_NONE = 2'd0,
      STATUS_OK   = 2'd1,
      STATUS_BAD  = 2'd2
   } status_type;

   typedef struct packed {
      status_type          status;
      logic [MARKER_W-1:0] sel;
      logic                bank;
   } job_type;

   typedef struct packed {
      logic pend_full;
      logic act_holds;
      logic act_bank;
   } emit_busy_type;

   typedef struct packed {
      status_type status;
      logic [7:0] id_char;
      logic       id_end;
   } rsp_item_type;

   localparam logic [7:0] MARKER_TEXT [MARKER_CNT][MARKER_MAXLEN] = '{
      '{8'h5B, 8'h69, 8'h64, 8'h20, 8'h22},
      '{8'h5B, 8'h69, 8'h64, 8'h20, 8'h27},
      '{8'h69, 8'h64, 8'h20, 8'h22, 8'h00},
      '{8'h69, 8'h64, 8'h20, 8'h27, 8'h00},
      '{8'h69, 8'h64, 8'h3A, 8'h00, 8'h00}
   };

   localparam logic [PROG_W-1:0] MARKER_LEN [MARKER_CNT] = '{
      3'd5, 3'd5, 3'd4, 3'd4, 3'd3
   };

   localparam logic [7:0] CLOSE_QUOTE [MARKER_CNT] = '{
      8'h22, 8'h27, 8'h22, 8'h27, 8'h00
   };

   function automatic logic [7:0] marker_char(input logic [MARKER_W-1:0] m,
                                              input logic [PROG_W-1:0] p);
      logic [7:0] c;
      c = 8'h00;
      if (m < MARKER_W'(MARKER_CNT) && p < PROG_W'(MARKER_MAXLEN)) begin
         c = MARKER_TEXT[m][p];
      end
      return c;
   endfunction

   function automatic logic id_char_ok(input logic [7:0] c);
      return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
             (c >= 8'h61 && c <= 8'h7A) || c == 8'h5F || c == 8'h2D ||
             c == 8'h2E || c == 8'h3A;
   endfunction

   function automatic logic is_white(input logic [7:0] c);
      return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
   endfunction

endpackage

// ===== sv/rie_if.sv =====
// ----------------------------------------------------------------------------
// rie channel interfaces
// valid/ready channels for message bytes, id results and the capacity register
// ----------------------------------------------------------------------------
interface rie_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] msg_byte;
   logic       msg_last;

   modport source (output valid, output msg_byte, output msg_last, input ready);
   modport sink   (input valid, input msg_byte, input msg_last, output ready);
endinterface

interface rie_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] status;
   logic [7:0] id_char;
   logic       id_end;

   modport source (output valid, output status, output id_char, output id_end,
                   input ready);
   modport sink   (input valid, input status, input id_char, input id_end,
                   output ready);
endinterface

interface rie_csr_if;
   logic       valid;
   logic       ready;
   logic [6:0] out_capacity;

   modport source (output valid, output out_capacity, input ready);
   modport sink   (input valid, input out_capacity, output ready);
endinterface

// ===== sv/rule_id_extractor.sv =====
// ----------------------------------------------------------------------------
// rule_id_extractor
// extracts a rule id from a byte-serial log message using five marker matchers
// ----------------------------------------------------------------------------
//  channel    | dir | payload                       | transaction
//  req_chan   | in  | msg_byte, msg_last            | one message byte
//  rsp_chan   | out | status, id_char, id_end       | one result
//  csr_chan   | in  | out_capacity                  | capacity register write
//
//  one message byte per cycle while ready; matcher state updates in the transaction's cycle
//  results pass job queue, active job, read stage and buffer; one per cycle while rsp_chan is ready
//  capture store has two banks; a new message stalls while its bank is still read out
//  synchronous active-high reset; no store clearing needed
//  rsp_chan stalls back up through a two-entry buffer and a one-deep job queue
// ----------------------------------------------------------------------------
module rule_id_extractor
   import rie_pkg::*;
#(
   parameter int MAX_ID_LEN = MAX_ID_LEN_DEF
) (
   input  logic      clock,
   input  logic      reset,
   rie_req_if.sink   req_chan,
   rie_rsp_if.source rsp_chan,
   rie_csr_if.sink   csr_chan
);

   localparam int ADDR_W = $clog2(MAX_ID_LEN + 1);

   logic [CAP_W-1:0]      cap_ff;
   logic                  accept;
   logic [MARKER_CNT-1:0] wr_en;
   logic [ADDR_W:0]       wr_addr [MARKER_CNT];
   logic                  wr_bank;
   logic                  job_valid;
   job_type               job;
   logic [ADDR_W-1:0]     job_len;
   emit_busy_type         busy;
   logic [ADDR_W:0]       rd_addr;
   logic [7:0]            rd_data [MARKER_CNT];

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET;
      end else if (csr_chan.valid && csr_chan.ready) begin
         cap_ff <= csr_chan.out_capacity;
      end
   end

   assign csr_chan.ready = 1'b1;
   assign req_chan.ready = !busy.pend_full && !(busy.act_holds && busy.act_bank == wr_bank);
   assign accept         = req_chan.valid && req_chan.ready;

   rie_match #(
      .MAX_ID_LEN (MAX_ID_LEN),
      .ADDR_W     (ADDR_W)
   ) u_match (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .msg_byte     (req_chan.msg_byte),
      .msg_last     (req_chan.msg_last),
      .out_capacity (cap_ff),
      .wr_en        (wr_en),
      .wr_addr      (wr_addr),
      .wr_bank      (wr_bank),
      .job_valid    (job_valid),
      .job          (job),
      .job_len      (job_len)
   );

   for (genvar g = 0; g < MARKER_CNT; g++) begin : g_mem
      rie_capmem #(
         .ADDR_W (ADDR_W)
      ) u_capmem (
         .clock   (clock),
         .wr_en   (wr_en[g]),
         .wr_addr (wr_addr[g]),
         .wr_data (req_chan.msg_byte),
         .rd_addr (rd_addr),
         .rd_data (rd_data[g])
      );
   end

   rie_emit #(
      .MAX_ID_LEN (MAX_ID_LEN),
      .ADDR_W     (ADDR_W)
   ) u_emit (
      .clock     (clock),
      .reset     (reset),
      .job_valid (job_valid),
      .job       (job),
      .job_len   (job_len),
      .busy      (busy),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .rsp       (rsp_chan)
   );

endmodule

// ===== sv/rie_capmem.sv =====
// ----------------------------------------------------------------------------
// rie_capmem
// two-bank capture store of one matcher, registered read
// ----------------------------------------------------------------------------
module rie_capmem #(
   parameter int ADDR_W = 6
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W:0]   wr_addr,
   input  logic [7:0]        wr_data,
   input  logic [ADDR_W:0]   rd_addr,
   output logic [7:0]        rd_data
);

   localparam int DEPTH = 2 ** (ADDR_W + 1);

   logic [7:0] mem_ff [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/rie_match.sv =====
// ----------------------------------------------------------------------------
// rie_match
// five parallel marker matchers with capture tracking and final id selection
// ----------------------------------------------------------------------------
module rie_match
   import rie_pkg::*;
#(
   parameter int MAX_ID_LEN = MAX_ID_LEN_DEF,
   parameter int ADDR_W     = $clog2(MAX_ID_LEN + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic [7:0]             msg_byte,
   input  logic                   msg_last,
   input  logic [CAP_W-1:0]       out_capacity,
   output logic [MARKER_CNT-1:0]  wr_en,
   output logic [ADDR_W:0]        wr_addr [MARKER_CNT],
   output logic                   wr_bank,
   output logic                   job_valid,
   output job_type                job,
   output logic [ADDR_W-1:0]      job_len
);

   localparam int LEN_W = $clog2(MAX_ID_LEN + 2);
   localparam logic [LEN_W-1:0] MAX_LEN_L = LEN_W'(MAX_ID_LEN);

   logic [PROG_W-1:0] prog_ff   [MARKER_CNT];
   logic [PROG_W-1:0] prog_in   [MARKER_CNT];
   logic              found_ff  [MARKER_CNT];
   logic              found_in  [MARKER_CNT];
   logic              closed_ff [MARKER_CNT];
   logic              closed_in [MARKER_CNT];
   logic              bad_ff    [MARKER_CNT];
   logic              bad_in    [MARKER_CNT];
   logic [LEN_W-1:0]  len_ff    [MARKER_CNT];
   logic [LEN_W-1:0]  len_in    [MARKER_CNT];
   logic              skip_ff;
   logic              skip_in;
   logic              bank_ff;

   logic [MARKER_W-1:0] sel;
   logic                hit;
   logic [LEN_W-1:0]    sel_len;
   status_type          status;

   always_comb begin
      logic [PROG_W-1:0] p;
      logic              app;
      skip_in = skip_ff;
      for (int m = 0; m < MARKER_CNT; m++) begin
         prog_in[m]   = prog_ff[m];
         found_in[m]  = found_ff[m];
         closed_in[m] = closed_ff[m];
         bad_in[m]    = bad_ff[m];
         len_in[m]    = len_ff[m];
         wr_en[m]     = 1'b0;
         wr_addr[m]   = {bank_ff, len_ff[m][ADDR_W-1:0]};
         p            = prog_ff[m];
         app          = 1'b0;
         if (!found_ff[m]) begin
            if (p < PROG_W'(MARKER_MAXLEN) && msg_byte == marker_char(MARKER_W'(m), p)) begin
               p = p + PROG_W'(1);
            end else if (msg_byte == marker_char(MARKER_W'(m), '0)) begin
               p = PROG_W'(1);
            end else begin
               p = '0;
            end
            if (p >= MARKER_LEN[m]) begin
               found_in[m]  = 1'b1;
               len_in[m]    = '0;
               closed_in[m] = 1'b0;
               bad_in[m]    = 1'b0;
               if (m == COLON_IDX) begin
                  skip_in = 1'b1;
               end
               p = '0;
            end
            prog_in[m] = p;
         end else if (!closed_ff[m]) begin
            if (m == COLON_IDX) begin
               if (!(skip_ff && msg_byte == 8'h20)) begin
                  skip_in = 1'b0;
                  if (is_white(msg_byte)) begin
                     closed_in[m] = 1'b1;
                  end else begin
                     app = 1'b1;
                  end
               end
            end else if (msg_byte == CLOSE_QUOTE[m]) begin
               closed_in[m] = 1'b1;
            end else begin
               app = 1'b1;
            end
            if (app) begin
               if (!id_char_ok(msg_byte)) begin
                  bad_in[m] = 1'b1;
               end
               if (len_ff[m] < MAX_LEN_L) begin
                  wr_en[m] = accept;
               end
               if (len_ff[m] <= MAX_LEN_L) begin
                  len_in[m] = len_ff[m] + LEN_W'(1);
               end
            end
         end
      end

      // highest priority found marker
      sel = '0;
      hit = 1'b0;
      for (int m = MARKER_CNT - 1; m >= 0; m--) begin
         if (found_in[m]) begin
            sel = MARKER_W'(m);
            hit = 1'b1;
         end
      end
      sel_len = len_in[sel];

      if (!hit) begin
         status = STATUS_NONE;
      end else if (sel == MARKER_W'(COLON_IDX) && sel_len == '0) begin
         status = STATUS_NONE;
      end else if (sel != MARKER_W'(COLON_IDX) && !closed_in[sel]) begin
         status = STATUS_BAD;
      end else if (sel_len == '0 || bad_in[sel] || sel_len > MAX_LEN_L ||
                   CAP_W'(sel_len) >= out_capacity) begin
         status = STATUS_BAD;
      end else begin
         status = STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int m = 0; m < MARKER_CNT; m++) begin
            prog_ff[m]   <= '0;
            found_ff[m]  <= 1'b0;
            closed_ff[m] <= 1'b0;
            bad_ff[m]    <= 1'b0;
            len_ff[m]    <= '0;
         end
         skip_ff <= 1'b0;
         bank_ff <= 1'b0;
      end else if (accept) begin
         if (msg_last) begin
            for (int m = 0; m < MARKER_CNT; m++) begin
               prog_ff[m]   <= '0;
               found_ff[m]  <= 1'b0;
               closed_ff[m] <= 1'b0;
               bad_ff[m]    <= 1'b0;
               len_ff[m]    <= '0;
            end
            skip_ff <= 1'b0;
            if (status == STATUS_OK) begin
               bank_ff <= !bank_ff;
            end
         end else begin
            for (int m = 0; m < MARKER_CNT; m++) begin
               prog_ff[m]   <= prog_in[m];
               found_ff[m]  <= found_in[m];
               closed_ff[m] <= closed_in[m];
               bad_ff[m]    <= bad_in[m];
               len_ff[m]    <= len_in[m];
            end
            skip_ff <= skip_in;
         end
      end
   end

   assign wr_bank    = bank_ff;
   assign job_valid  = accept && msg_last;
   assign job.status = status;
   assign job.sel    = sel;
   assign job.bank   = bank_ff;
   assign job_len    = sel_len[ADDR_W-1:0];

endmodule

// ===== sv/rie_emit.sv =====
// ----------------------------------------------------------------------------
// rie_emit
// job queue, capture read sequencer and two-entry result buffer
// ----------------------------------------------------------------------------
module rie_emit
   import rie_pkg::*;
#(
   parameter int MAX_ID_LEN = MAX_ID_LEN_DEF,
   parameter int ADDR_W     = $clog2(MAX_ID_LEN + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   input  job_type           job,
   input  logic [ADDR_W-1:0] job_len,
   output emit_busy_type     busy,
   output logic [ADDR_W:0]   rd_addr,
   input  logic [7:0]        rd_data [MARKER_CNT],
   rie_rsp_if.source         rsp
);

   `include "rule_id_extractor_assert.svh"

   logic                pend_valid_ff, pend_valid_in;
   job_type             pend_ff, pend_in;
   logic [ADDR_W-1:0]   pend_len_ff, pend_len_in;
   logic                act_valid_ff, act_valid_in;
   job_type             act_ff, act_in;
   logic [ADDR_W-1:0]   act_len_ff, act_len_in;
   logic [ADDR_W-1:0]   k_ff, k_in;
   logic                p_valid_ff;
   status_type          p_status_ff;
   logic                p_end_ff;
   logic [MARKER_W-1:0] p_sel_ff;
   rsp_item_type        fifo_ff [2];
   logic                wr_ptr_ff;
   logic                rd_ptr_ff;
   logic [1:0]          cnt_ff, cnt_in;

   logic                pop;
   logic [2:0]          occ;
   logic                issue;
   logic [ADDR_W-1:0]   k_next;
   logic                is_end;
   logic                act_free;
   logic [7:0]          sel_char;
   rsp_item_type        push_item;

   assign pop      = rsp.valid && rsp.ready;
   assign occ      = {1'b0, cnt_ff} + {2'b00, p_valid_ff};
   assign issue    = act_valid_ff && (occ < 3'd2 || pop);
   assign k_next   = k_ff + ADDR_W'(1);
   assign is_end   = (act_ff.status != STATUS_OK) || (k_next == act_len_ff);
   assign act_free = !act_valid_ff || (issue && is_end);
   assign rd_addr  = {act_ff.bank, k_ff};

   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      pend_len_in   = pend_len_ff;
      act_valid_in  = act_valid_ff;
      act_in        = act_ff;
      act_len_in    = act_len_ff;
      k_in          = k_ff;
      if (act_free) begin
         act_valid_in = pend_valid_ff;
         act_in       = pend_ff;
         act_len_in   = pend_len_ff;
         k_in         = '0;
         pend_valid_in = 1'b0;
      end else if (issue) begin
         k_in = k_next;
      end
      if (job_valid) begin
         pend_valid_in = 1'b1;
         pend_in       = job;
         pend_len_in   = job_len;
      end
   end

   always_comb begin
      sel_char = '0;
      if (p_status_ff == STATUS_OK && p_sel_ff < MARKER_W'(MARKER_CNT)) begin
         sel_char = rd_data[p_sel_ff];
      end
      push_item.status  = p_status_ff;
      push_item.id_char = sel_char;
      push_item.id_end  = p_end_ff;
      cnt_in = cnt_ff + {1'b0, p_valid_ff} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         act_valid_ff  <= 1'b0;
         k_ff          <= '0;
         p_valid_ff    <= 1'b0;
         wr_ptr_ff     <= 1'b0;
         rd_ptr_ff     <= 1'b0;
         cnt_ff        <= '0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         act_valid_ff  <= act_valid_in;
         k_ff          <= k_in;
         p_valid_ff    <= issue;
         cnt_ff        <= cnt_in;
         if (p_valid_ff) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      pend_ff     <= pend_in;
      pend_len_ff <= pend_len_in;
      act_ff      <= act_in;
      act_len_ff  <= act_len_in;
      p_status_ff <= act_ff.status;
      p_end_ff    <= is_end;
      p_sel_ff    <= act_ff.sel;
      if (p_valid_ff) begin
         fifo_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign busy.pend_full = pend_valid_ff;
   assign busy.act_holds = act_valid_ff && act_ff.status == STATUS_OK;
   assign busy.act_bank  = act_ff.bank;

   assign rsp.valid   = cnt_ff != 2'd0;
   assign rsp.status  = fifo_ff[rd_ptr_ff].status;
   assign rsp.id_char = fifo_ff[rd_ptr_ff].id_char;
   assign rsp.id_end  = fifo_ff[rd_ptr_ff].id_end;

   `RIE_ASSERT_SAME(a_occ_limit, clock, reset, 1'b1, occ <= 3'd2, "result buffer overfilled")
   `RIE_ASSERT_SAME(a_rd_in_range, clock, reset, issue && act_ff.status == STATUS_OK, k_ff < act_len_ff, "read beyond id")
   `RIE_ASSERT_SAME(a_pend_overrun, clock, reset, job_valid, !pend_valid_ff, "job queue overrun")
   `RIE_ASSERT_NEXT(a_end_frees, clock, reset, issue && is_end && !pend_valid_ff && !job_valid, !act_valid_ff, "finished job not released")

endmodule
